/* rtl/mvsm_pkg.sv */
// Shared constants, types and codes of the multi-voice stereo mixer.
package mvsm_pkg;

  localparam int VOICES      = 16;
  localparam int VIDX_W      = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int LENGTH_BITS = 24;
  localparam int GAIN_W      = 16;
  localparam int REC_W       = LENGTH_BITS + 2 * GAIN_W;
  localparam int ACC_W       = 24;

  localparam logic [31:0] MAX_LEN = 32'((64'd1 << LENGTH_BITS) - 64'd1);

  localparam logic [15:0] UNITY_GAIN      = 16'd32768;
  localparam logic [15:0] PAN_SCALE_RST   = 16'd164;
  localparam logic [15:0] QUIET_LIMIT_RST = 16'd328;

  localparam logic signed [24:0] ACC_MAX = 25'sd8388607;
  localparam logic signed [24:0] ACC_MIN = -25'sd8388608;
  localparam logic signed [23:0] OUT_MAX = 24'sd32767;
  localparam logic signed [23:0] OUT_MIN = -24'sd32768;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAN_SCALE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUIET_LIMIT = 2'd1;

  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_MIX   = 1'b1;

  localparam logic [1:0] STAT_STARTED = 2'd0;
  localparam logic [1:0] STAT_QUIET   = 2'd1;
  localparam logic [1:0] STAT_NO_FREE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAN_MUL,
    ST_GAIN_MUL,
    ST_START_COMMIT,
    ST_VOICE_READ,
    ST_SAMPLE_MUL,
    ST_SAMPLE_ACC
  } state_e;

  typedef struct packed {
    logic capture;
    logic pan_mul;
    logic gain_mul;
    logic start_commit;
    logic sample_mul;
    logic sample_acc;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic              kind;
    logic [1:0]        status;
    logic [3:0]        granted;
    logic signed [15:0] mix_left;
    logic signed [15:0] mix_right;
    logic              clipped;
  } result_t;

endpackage

/* rtl/mvsm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mvsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/mvsm_ctrl.sv */
// Sequencer that steps each request through the mixer datapath.
module mvsm_ctrl
  import mvsm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_type_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = (in_type_i == REQ_SAMPLE) ? ST_VOICE_READ : ST_PAN_MUL;
        end
      end
      ST_PAN_MUL: begin
        cmd_o.pan_mul = 1'b1;
        state_d = ST_GAIN_MUL;
      end
      ST_GAIN_MUL: begin
        // Hold here until the output register can take the response.
        cmd_o.gain_mul = 1'b1;
        if (stat_i.out_free) begin
          state_d = ST_START_COMMIT;
        end
      end
      ST_START_COMMIT: begin
        cmd_o.start_commit = 1'b1;
        state_d = ST_IDLE;
      end
      ST_VOICE_READ: begin
        state_d = ST_SAMPLE_MUL;
      end
      ST_SAMPLE_MUL: begin
        cmd_o.sample_mul = 1'b1;
        if (stat_i.out_free) begin
          state_d = ST_SAMPLE_ACC;
        end
      end
      ST_SAMPLE_ACC: begin
        cmd_o.sample_acc = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/mvsm_dpath.sv */
// Datapath: request capture, pan and gain math, voice store, accumulators, output register.
module mvsm_dpath
  import mvsm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output stat_t                 stat_o,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  input  logic [23:0]           sound_frames_i,
  input  logic [15:0]           volume_i,
  input  logic signed [15:0]    pan_offset_i,
  input  logic [3:0]            voice_index_i,
  input  logic signed [15:0]    left_sample_i,
  input  logic signed [15:0]    right_sample_i,
  input  logic                  last_voice_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output result_t               result_o
);

  function automatic logic signed [17:0] scale_f(input logic signed [32:0] p);
    logic [32:0] m;
    logic [17:0] s;
    m = p[32] ? 33'(-p) : 33'(p);
    s = {1'b0, m[31:15]};
    return p[32] ? -$signed(s) : $signed(s);
  endfunction

  function automatic logic signed [23:0] acc_add_f(input logic signed [23:0] a,
                                                   input logic signed [17:0] b);
    logic signed [24:0] sum;
    sum = 25'(a) + 25'(b);
    if (sum > ACC_MAX) begin
      sum = ACC_MAX;
    end else if (sum < ACC_MIN) begin
      sum = ACC_MIN;
    end
    return sum[23:0];
  endfunction

  // Configuration registers.
  logic [15:0] pan_scale_q, quiet_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_scale_q   <= PAN_SCALE_RST;
      quiet_limit_q <= QUIET_LIMIT_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_PAN_SCALE) begin
        pan_scale_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_QUIET_LIMIT) begin
        quiet_limit_q <= cfg_data_i;
      end
    end
  end

  // Captured request, with volume and length saturated on the way in.
  logic [LENGTH_BITS-1:0] frames_q;
  logic [15:0]            vol_q, abs_off_q;
  logic                   off_neg_q, off_pos_q;
  logic [3:0]             vidx_q;
  logic signed [15:0]     ls_q, rs_q;
  logic                   last_q;
  logic [31:0]            frames_ext;

  assign frames_ext = 32'(sound_frames_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      frames_q  <= LENGTH_BITS'((frames_ext > MAX_LEN) ? MAX_LEN : frames_ext);
      vol_q     <= (volume_i > UNITY_GAIN) ? UNITY_GAIN : volume_i;
      abs_off_q <= pan_offset_i[15] ? 16'(-pan_offset_i) : 16'(pan_offset_i);
      off_neg_q <= pan_offset_i[15];
      off_pos_q <= !pan_offset_i[15] && (pan_offset_i != 16'sd0);
      vidx_q    <= voice_index_i;
      ls_q      <= left_sample_i;
      rs_q      <= right_sample_i;
      last_q    <= last_voice_i;
    end
  end

  // Pan magnitude, then the two volume-scaled gains.
  logic [31:0] mag_q;
  logic [16:0] far_diff;
  logic [15:0] far_gain, lg, rg;
  logic [31:0] lprod, rprod;
  logic [15:0] lgain_q, rgain_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pan_mul) begin
      mag_q <= abs_off_q * pan_scale_q;
    end
    if (cmd_i.gain_mul) begin
      lgain_q <= lprod[30:15];
      rgain_q <= rprod[30:15];
    end
  end

  always_comb begin
    far_diff = 17'h10000 - {1'b0, mag_q[15:0]};
    far_gain = (mag_q[31:16] != 16'd0) ? 16'd0 : far_diff[16:1];
    lg       = off_pos_q ? far_gain : UNITY_GAIN;
    rg       = off_neg_q ? far_gain : UNITY_GAIN;
    lprod    = vol_q * lg;
    rprod    = vol_q * rg;
  end

  // Voice activity flags and lowest free voice.
  logic [VOICES-1:0] active_q, active_d;
  logic [VIDX_W-1:0] free_idx;
  logic              free_any;

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_idx = VIDX_W'(i);
        free_any = 1'b1;
      end
    end
  end

  // Voice store: {remaining, left gain, right gain}.
  logic              ram_we;
  logic [VIDX_W-1:0] ram_waddr, vaddr;
  logic [REC_W-1:0]  ram_wdata, ram_rdata;

  assign vaddr = VIDX_W'(vidx_q);

  mvsm_ram #(
    .WIDTH (REC_W),
    .DEPTH (VOICES)
  ) u_voice_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (vaddr),
    .rdata_o (ram_rdata)
  );

  // Sample scaling.
  logic signed [32:0]      lp_q, rp_q;
  logic [LENGTH_BITS-1:0]  rem_q;
  logic [GAIN_W-1:0]       rd_lgain, rd_rgain;

  assign rd_lgain = ram_rdata[2*GAIN_W-1:GAIN_W];
  assign rd_rgain = ram_rdata[GAIN_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_mul) begin
      lp_q  <= ls_q * $signed({1'b0, rd_lgain});
      rp_q  <= rs_q * $signed({1'b0, rd_rgain});
      rem_q <= ram_rdata[REC_W-1:2*GAIN_W];
    end
  end

  // Accumulate, write back the voice and form results.
  logic signed [23:0] acc_l_q, acc_r_q, acc_l_d, acc_r_d;
  logic signed [23:0] sum_l, sum_r;
  logic               voice_ok, quiet;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic               out_valid_q, out_load;
  result_t            result_q, result_d;
  logic               clip_l, clip_r;

  assign rem_dec  = rem_q - LENGTH_BITS'(1);
  assign voice_ok = (32'(vidx_q) < 32'(VOICES)) && active_q[vaddr];
  assign quiet    = vol_q < quiet_limit_q;
  assign sum_l    = acc_add_f(acc_l_q, scale_f(lp_q));
  assign sum_r    = acc_add_f(acc_r_q, scale_f(rp_q));

  always_comb begin
    active_d  = active_q;
    acc_l_d   = acc_l_q;
    acc_r_d   = acc_r_q;
    ram_we    = 1'b0;
    ram_waddr = free_idx;
    ram_wdata = {frames_q, lgain_q, rgain_q};
    out_load  = 1'b0;
    result_d  = '0;
    clip_l    = 1'b0;
    clip_r    = 1'b0;
    if (cmd_i.start_commit) begin
      out_load        = 1'b1;
      result_d.kind   = KIND_START;
      if (quiet) begin
        result_d.status = STAT_QUIET;
      end else if (!free_any) begin
        result_d.status = STAT_NO_FREE;
      end else begin
        result_d.status   = STAT_STARTED;
        result_d.granted  = 4'(free_idx);
        ram_we            = 1'b1;
        active_d[free_idx] = 1'b1;
      end
    end
    if (cmd_i.sample_acc) begin
      ram_waddr = vaddr;
      ram_wdata = {rem_dec, rd_lgain, rd_rgain};
      if (voice_ok) begin
        if (rem_q == '0) begin
          active_d[vaddr] = 1'b0;
        end else begin
          acc_l_d = sum_l;
          acc_r_d = sum_r;
          ram_we  = 1'b1;
          if (rem_dec == '0) begin
            active_d[vaddr] = 1'b0;
          end
        end
      end
      if (last_q) begin
        out_load      = 1'b1;
        result_d.kind = KIND_MIX;
        priority if (acc_l_d > OUT_MAX) begin
          result_d.mix_left = 16'sh7fff;
          clip_l = 1'b1;
        end else if (acc_l_d < OUT_MIN) begin
          result_d.mix_left = -16'sh8000;
          clip_l = 1'b1;
        end else begin
          result_d.mix_left = acc_l_d[15:0];
        end
        priority if (acc_r_d > OUT_MAX) begin
          result_d.mix_right = 16'sh7fff;
          clip_r = 1'b1;
        end else if (acc_r_d < OUT_MIN) begin
          result_d.mix_right = -16'sh8000;
          clip_r = 1'b1;
        end else begin
          result_d.mix_right = acc_r_d[15:0];
        end
        result_d.clipped = clip_l || clip_r;
        acc_l_d = '0;
        acc_r_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '0;
      acc_l_q     <= '0;
      acc_r_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      acc_l_q  <= acc_l_d;
      acc_r_q  <= acc_r_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      result_q <= result_d;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign result_o        = result_q;

endmodule

/* rtl/multi_voice_stereo_mixer.sv */
// Top level of the multi-voice stereo mixer: stream ports, sequencer and datapath.
// One request at a time; a result reaches the output register after its request passes
// through the sequencer states (start: pan multiply, gain multiply, commit; sample: voice store
// read, sample multiply, accumulate). A new request is taken only after the last one is
// through; the sequencer stalls only while a result waits unread. Reset clears all voices, both
// accumulators and the output, and restores the configuration; the voice store is not cleared.
module multi_voice_stereo_mixer
  import mvsm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // sound_frames[23:0], volume[39:24], pan_offset[55:40], voice_index[59:56],
  // left_sample[75:60], right_sample[91:76], zero padding[95:92]
  input  logic [95:0]          s_axis_tdata,
  // req_type[0]
  input  logic [0:0]           s_axis_tuser,
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // start_status[1:0], granted_voice[5:2], mix_left[21:6], mix_right[37:22],
  // clipped[38], zero padding[39]
  output logic [39:0]          m_axis_tdata,
  // result_kind[0]
  output logic [0:0]           m_axis_tuser,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  cmd_t    cmd;
  stat_t   stat;
  result_t result;

  assign cfg_ready_o = 1'b1;

  mvsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_type_i  (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mvsm_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .sound_frames_i (s_axis_tdata[23:0]),
    .volume_i       (s_axis_tdata[39:24]),
    .pan_offset_i   (s_axis_tdata[55:40]),
    .voice_index_i  (s_axis_tdata[59:56]),
    .left_sample_i  (s_axis_tdata[75:60]),
    .right_sample_i (s_axis_tdata[91:76]),
    .last_voice_i   (s_axis_tlast),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .result_o       (result)
  );

  assign m_axis_tdata = {1'b0, result.clipped, result.mix_right, result.mix_left,
                         result.granted, result.status};
  assign m_axis_tuser = result.kind;

endmodule

/* rtl/mvsm_checker.sv */
// Port-level checks on the mixer, bound to the top level.
module mvsm_checker
  import mvsm_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [39:0]          m_axis_tdata,
  input logic [0:0]           m_axis_tuser
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // The mixer works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while busy");

  // A mixed frame carries no start status or voice.
  a_mix_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[0] == KIND_MIX) |-> m_axis_tdata[5:0] == 6'd0)
    else $error("mixed frame carries start fields");

  // A start response carries no mix, and a legal status.
  a_start_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[0] == KIND_START) |->
      m_axis_tdata[39:6] == 34'd0 && m_axis_tdata[1:0] != 2'd3)
    else $error("start response malformed");

endmodule

bind multi_voice_stereo_mixer mvsm_checker u_mvsm_checker (.*);

/* dv/tb_top.sv */
// Self-checking testbench for multi_voice_stereo_mixer: directed and random traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mvsm_pkg::*;

  typedef struct {
    logic               req_kind;
    logic [23:0]        frames;
    logic [15:0]        volume;
    logic signed [15:0] pan;
    logic [3:0]         voice;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               last;
  } mix_req_t;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [95:0]          s_axis_tdata  = '0;
  logic [0:0]           s_axis_tuser  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [39:0]          m_axis_tdata;
  logic [0:0]           m_axis_tuser;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [15:0]          cfg_data_i    = '0;

  // Mirror of the block's configuration and voice state.
  logic [15:0] pan_scale_q   = PAN_SCALE_RST;
  logic [15:0] quiet_limit_q = QUIET_LIMIT_RST;
  logic        voice_on [VOICES] = '{default: 1'b0};
  logic [23:0] frames_left [VOICES];
  logic [16:0] gain_l [VOICES];
  logic [16:0] gain_r [VOICES];
  longint      acc_l = 0;
  longint      acc_r = 0;

  result_t outputs_due[$];
  int      n_errors  = 0;
  int      idle_pct  = 0;
  int      stall_pct = 0;

  multi_voice_stereo_mixer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int lowest_free();
    int slot;
    slot = -1;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (!voice_on[v]) slot = v;
    end
    return slot;
  endfunction

  // Product truncated toward zero, as the block scales magnitude and restores sign.
  function automatic longint scale_by_gain(longint smp, longint g);
    longint prod;
    longint mag;
    prod = smp * g;
    mag  = (prod < 0) ? -prod : prod;
    mag  = mag >> 15;
    return (prod < 0) ? -mag : mag;
  endfunction

  function automatic longint acc_sat(longint a, longint b);
    longint r;
    r = a + b;
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return r;
  endfunction

  task automatic predict_mixer_item(input mix_req_t r);
    result_t res;
    longint  vol;
    longint  off;
    longint  mag;
    longint  far_g;
    longint  lg;
    longint  rg;
    longint  l;
    longint  rr;
    int      slot;
    res = '0;
    if (r.req_kind == REQ_START) begin
      res.kind = KIND_START;
      vol = longint'(r.volume);
      if (vol > 32768) vol = 32768;
      if (vol < longint'(quiet_limit_q)) begin
        res.status = STAT_QUIET;
      end else begin
        off   = longint'(r.pan);
        mag   = ((off < 0) ? -off : off) * longint'(pan_scale_q);
        far_g = (mag >= 65536) ? 0 : ((65536 - mag) >> 1);
        lg    = 32768;
        rg    = 32768;
        if (off < 0) rg = far_g;
        else if (off > 0) lg = far_g;
        slot = lowest_free();
        if (slot < 0) begin
          res.status = STAT_NO_FREE;
        end else begin
          voice_on[slot]    = 1'b1;
          frames_left[slot] = r.frames;
          gain_l[slot]      = 17'((vol * lg) >> 15);
          gain_r[slot]      = 17'((vol * rg) >> 15);
          res.status        = STAT_STARTED;
          res.granted       = 4'(slot);
        end
      end
      outputs_due.push_back(res);
    end else begin
      if (voice_on[r.voice]) begin
        if (frames_left[r.voice] == 0) begin
          voice_on[r.voice] = 1'b0;
        end else begin
          acc_l = acc_sat(acc_l, scale_by_gain(longint'(r.left), longint'(gain_l[r.voice])));
          acc_r = acc_sat(acc_r, scale_by_gain(longint'(r.right), longint'(gain_r[r.voice])));
          frames_left[r.voice] = frames_left[r.voice] - 24'd1;
          if (frames_left[r.voice] == 0) voice_on[r.voice] = 1'b0;
        end
      end
      if (r.last) begin
        res.kind = KIND_MIX;
        l  = acc_l;
        rr = acc_r;
        if (l > 32767) begin
          l = 32767;
          res.clipped = 1'b1;
        end else if (l < -32768) begin
          l = -32768;
          res.clipped = 1'b1;
        end
        if (rr > 32767) begin
          rr = 32767;
          res.clipped = 1'b1;
        end else if (rr < -32768) begin
          rr = -32768;
          res.clipped = 1'b1;
        end
        res.mix_left  = 16'(l);
        res.mix_right = 16'(rr);
        outputs_due.push_back(res);
        acc_l = 0;
        acc_r = 0;
      end
    end
  endtask

  function automatic mix_req_t start_req(logic [23:0] frames, logic [15:0] volume,
                                         logic signed [15:0] pan);
    mix_req_t r;
    r = '{REQ_START, frames, volume, pan, 4'd0, 16'sd0, 16'sd0, 1'b0};
    return r;
  endfunction

  function automatic mix_req_t sample_req(logic [3:0] voice, logic signed [15:0] left,
                                          logic signed [15:0] right, logic last);
    mix_req_t r;
    r = '{REQ_SAMPLE, 24'd0, 16'd0, 16'sd0, voice, left, right, last};
    return r;
  endfunction

  function automatic logic signed [15:0] rand_sample();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    return 16'($urandom);
  endfunction

  // Holds the request until it is taken; valid stays high into the next request
  // unless the sender decides to idle.
  task automatic send_item(input mix_req_t r);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, r.right, r.left, r.voice, r.pan, r.volume, r.frames};
    s_axis_tuser  <= r.req_kind;
    s_axis_tlast  <= r.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_mixer_item(r);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // A sample with last_voice 0 gives no result, so some slack follows the last one.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (outputs_due.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_PAN_SCALE) pan_scale_q = val;
    else if (idx == CFG_QUIET_LIMIT) quiet_limit_q = val;
    @(posedge clk_i);
  endtask

  // One output frame of samples, chiefly for active voices; last_voice on the last.
  task automatic send_mix_frame(input bit rand_fill, input logic signed [15:0] l0,
                                input logic signed [15:0] r0, inout int sent);
    int voices_q[$];
    for (int v = 0; v < VOICES; v++) begin
      if (voice_on[v] && (!rand_fill || $urandom_range(99) < 85)) voices_q.push_back(v);
    end
    if (rand_fill && $urandom_range(9) == 0) voices_q.push_back($urandom_range(VOICES - 1));
    if (voices_q.size() == 0) voices_q.push_back($urandom_range(VOICES - 1));
    foreach (voices_q[i]) begin
      send_item(sample_req(4'(voices_q[i]), rand_fill ? rand_sample() : l0,
                           rand_fill ? rand_sample() : r0, i == voices_q.size() - 1));
      sent++;
    end
  endtask

  task automatic test_start_paths();
    send_item(start_req(24'd3, 16'd32768, 16'sd0));
    send_item(start_req(24'd2, 16'd20000, -16'sd200));
    send_item(start_req(24'hFFFFFF, 16'hFFFF, 16'sd400));
    send_item(start_req(24'd5, 16'd327, 16'sd10));
    // Zero-length sound at exactly the quiet limit, far left.
    send_item(start_req(24'd0, QUIET_LIMIT_RST, 16'sh8000));
    send_item(start_req(24'd1, 16'd0, 16'sh7FFF));
    send_item(sample_req(4'd0, 16'sh7FFF, 16'sh8000, 1'b0));
    send_item(sample_req(4'd1, 16'sh8000, 16'sh7FFF, 1'b0));
    send_item(sample_req(4'd2, 16'sh7FFF, 16'sh7FFF, 1'b0));
    send_item(sample_req(4'd3, 16'sd12345, -16'sd12345, 1'b0));
    send_item(sample_req(4'd15, -16'sd1, 16'sd1, 1'b1));
    send_item(sample_req(4'd0, 16'sh7FFF, 16'sh7FFF, 1'b0));
    send_item(sample_req(4'd0, 16'sh7FFF, 16'sh7FFF, 1'b0));
    send_item(sample_req(4'd1, 16'sh7FFF, 16'sh8000, 1'b1));
    send_item(sample_req(4'd0, 16'sd0, 16'sd0, 1'b1));
    wait_drained();
  endtask

  task automatic test_voice_exhaustion();
    int sent;
    sent = 0;
    for (int i = 0; i < VOICES; i++) begin
      send_item(start_req(24'd1, 16'd16384, $signed(16'(i * 2000 - 16000))));
    end
    send_mix_frame(1'b0, 16'sd1000, -16'sd1000, sent);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    int sent;
    sent = 0;
    write_reg(CFG_PAN_SCALE, 16'd0);
    write_reg(CFG_QUIET_LIMIT, 16'd0);
    send_item(start_req(24'd2, 16'd0, 16'sh8000));
    send_item(start_req(24'd2, 16'd32768, 16'sh7FFF));
    send_mix_frame(1'b0, 16'sh7FFF, 16'sh8000, sent);
    wait_drained();
    write_reg(CFG_PAN_SCALE, 16'hFFFF);
    write_reg(CFG_QUIET_LIMIT, 16'd32768);
    send_item(start_req(24'd1, 16'd32767, 16'sd0));
    send_item(start_req(24'd1, 16'd32768, 16'sd1));
    send_item(start_req(24'd1, 16'd40000, -16'sd1));
    send_mix_frame(1'b0, 16'sh8000, 16'sh7FFF, sent);
    send_mix_frame(1'b0, 16'sh7FFF, 16'sh7FFF, sent);
    wait_drained();
  endtask

  // Many full-scale samples of one voice in a single frame drive both
  // accumulators into their 24-bit limits.
  task automatic test_acc_saturation();
    int slot;
    write_reg(CFG_PAN_SCALE, PAN_SCALE_RST);
    write_reg(CFG_QUIET_LIMIT, QUIET_LIMIT_RST);
    slot = lowest_free();
    send_item(start_req(24'd261, 16'd32768, 16'sd0));
    for (int i = 0; i < 261; i++) begin
      send_item(sample_req(4'(slot), 16'sh7FFF, 16'sh8000, i == 260));
    end
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int          sent;
    int          n_starts;
    logic [15:0] vol;
    logic [23:0] frames;
    longint      vol_sat;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 63;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 63;
        end
        default: begin
          idle_pct  = 21;
          stall_pct = 21;
        end
      endcase
      if (phase == 3) begin
        write_reg(CFG_PAN_SCALE, 16'($urandom));
        write_reg(CFG_QUIET_LIMIT, 16'($urandom_range(0, 32768)));
      end else begin
        write_reg(CFG_PAN_SCALE, 16'($urandom_range(0, 400)));
        write_reg(CFG_QUIET_LIMIT, 16'($urandom_range(0, 2000)));
      end
      sent = 0;
      while (sent < 70) begin
        n_starts = ($urandom_range(9) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 2);
        repeat (n_starts) begin
          vol = ($urandom_range(6) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
          vol_sat = (vol > 16'd32768) ? 32768 : longint'(vol);
          // Long sounds would hold a voice for the rest of the run, so they go
          // mostly into starts that will not take a voice.
          if (lowest_free() < 0 || vol_sat < longint'(quiet_limit_q) ||
              $urandom_range(59) == 0) begin
            frames = 24'($urandom);
          end else if ($urandom_range(19) == 0) begin
            frames = 24'd0;
          end else begin
            frames = 24'($urandom_range(1, 12));
          end
          send_item(start_req(frames, vol, $urandom_range(1) ? 16'($urandom) :
                              $signed(16'(int'($urandom_range(0, 1200)) - 600))));
          sent++;
        end
        send_mix_frame(1'b1, 16'sd0, 16'sd0, sent);
      end
      wait_drained();
    end
  endtask

  function automatic void check_field(string fname, longint want, longint got);
    if (want != got) begin
      n_errors++;
      $error("%s expected %0d got %0d", fname, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : check_outputs
    result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (outputs_due.size() == 0) begin
        n_errors++;
        $error("result with none outstanding: tuser %0d tdata %h", m_axis_tuser, m_axis_tdata);
      end else begin
        want = outputs_due.pop_front();
        check_field("result_kind", want.kind, m_axis_tuser[0]);
        check_field("start_status", want.status, m_axis_tdata[1:0]);
        check_field("granted_voice", want.granted, m_axis_tdata[5:2]);
        check_field("mix_left", want.mix_left, $signed(m_axis_tdata[21:6]));
        check_field("mix_right", want.mix_right, $signed(m_axis_tdata[37:22]));
        check_field("clipped", want.clipped, m_axis_tdata[38]);
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #500_000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_start_paths();
    test_voice_exhaustion();
    test_register_extremes();
    test_acc_saturation();
    test_random_traffic();
    if (outputs_due.size() != 0) n_errors++;
    if (n_errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/mvsm_pkg.sv
rtl/mvsm_ram.sv
rtl/mvsm_ctrl.sv
rtl/mvsm_dpath.sv
rtl/multi_voice_stereo_mixer.sv
rtl/mvsm_checker.sv
dv/tb_top.sv
